@@ sv/cct_pkg.sv @@
// ----------------------------------------------------------------------------
// cct_pkg
// Shared types and constants for the climate frame translator pipeline.
// ----------------------------------------------------------------------------
package cct_pkg;

   localparam int ID_W       = 29;
   localparam int CSR_ADDR_W = 3;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 24;

   // register indexes on the csr port
   localparam logic [CSR_ADDR_W-1:0] CSR_DISPLAY_FRAME_ID = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ECONOMY_ID       = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_CLIMATE_ID_ONE   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_CLIMATE_ID_TWO   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_CLIMATE_ID_THREE = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_ECONOMY_ENABLE   = 3'd5;

   localparam logic signed [8:0]  TEMP_OFFSET    = 9'sd40;
   localparam logic signed [8:0]  FAHR_OFFSET    = 9'sd32;
   localparam logic [12:0]        RECIP_NINE     = 13'd7282;
   localparam logic signed [9:0]  SEG_HIGH       = 10'sd80;
   localparam logic signed [9:0]  SEG_MID        = 10'sd20;
   localparam logic signed [9:0]  SEG_LOW        = -10'sd20;
   localparam logic [11:0]        SLOPE_HIGH     = 12'hFEB;  // -21
   localparam logic [11:0]        SLOPE_UPPER    = 12'hFEA;  // -22
   localparam logic [11:0]        SLOPE_MID      = 12'hFE9;  // -23
   localparam logic [11:0]        SLOPE_LOW      = 12'hFE8;  // -24
   localparam logic [11:0]        LINE_OFFSET    = 12'd2752;
   localparam logic [7:0]         ECON_BIT       = 8'h20;
   localparam int                 FAHR_FLAG_BIT  = 5;

   typedef struct packed {
      logic [ID_W-1:0] display_frame_id;
      logic [ID_W-1:0] economy_id;
      logic [ID_W-1:0] climate_id_one;
      logic [ID_W-1:0] climate_id_two;
      logic [ID_W-1:0] climate_id_three;
      logic            economy_enable;
   } cfg_type;

   typedef struct packed {
      logic            from_unit;
      logic [ID_W-1:0] frame_id;
      logic [7:0]      byte_zero;
      logic [7:0]      byte_two;
      logic [7:0]      byte_three;
      logic [7:0]      byte_five;
      logic            economy_switch;
   } req_type;

   // flags that ride along unchanged once decided
   typedef struct packed {
      logic       forward;
      logic [7:0] out_byte_three;
      logic       dac_write;
      logic       ac_update;
      logic       ac_enable;
   } flags_type;

   typedef struct packed {
      flags_type         flags;
      logic              fahrenheit;
      logic signed [9:0] x_cel;
      logic              f_neg;
      logic [10:0]       f_mag;
   } s1_type;

   typedef struct packed {
      flags_type         flags;
      logic signed [9:0] x;
   } s2_type;

   typedef struct packed {
      logic       ac_enable;
      logic       ac_update;
      logic [11:0] dac_value;
      logic       dac_write;
      logic [7:0] out_byte_three;
      logic       forward;
   } rsp_type;

endpackage

@@ sv/cct_decode.sv @@
// ----------------------------------------------------------------------------
// cct_decode
// First stage: identifier match, flag decisions and temperature prescale.
// ----------------------------------------------------------------------------
module cct_decode (
   input  logic             clock,
   input  logic             reset,
   input  cct_pkg::cfg_type cfg,
   input  logic             up_valid,
   output logic             up_ready,
   input  cct_pkg::req_type up_data,
   output logic             dn_valid,
   input  logic             dn_ready,
   output cct_pkg::s1_type  dn_data
);

   logic            valid_ff;
   cct_pkg::s1_type data_ff;
   cct_pkg::s1_type data_in;

   logic              hit_temp;
   logic              hit_econ;
   logic              hit_one;
   logic              hit_two;
   logic              hit_three;
   logic signed [8:0] temp_c;
   logic signed [8:0] temp_f;
   logic signed [11:0] temp_f_ext;
   logic signed [11:0] scaled;
   logic [11:0]        scaled_neg;

   always_comb begin
      hit_temp  = up_data.frame_id == cfg.display_frame_id;
      hit_econ  = up_data.frame_id == cfg.economy_id;
      hit_one   = up_data.frame_id == cfg.climate_id_one;
      hit_two   = up_data.frame_id == cfg.climate_id_two;
      hit_three = up_data.frame_id == cfg.climate_id_three;

      temp_c     = $signed({1'b0, up_data.byte_two}) - cct_pkg::TEMP_OFFSET;
      temp_f     = temp_c - cct_pkg::FAHR_OFFSET;
      temp_f_ext = $signed({{3{temp_f[8]}}, temp_f});
      scaled     = (temp_f_ext <<< 3) + (temp_f_ext <<< 1);
      scaled_neg = -scaled;

      data_in.flags.forward        = 1'b1;
      data_in.flags.out_byte_three = up_data.byte_three;
      data_in.flags.dac_write      = 1'b0;
      data_in.flags.ac_update      = 1'b0;
      data_in.flags.ac_enable      = 1'b0;
      if (!up_data.from_unit) begin
         if (hit_temp) begin
            data_in.flags.dac_write = 1'b1;
         end else if (hit_econ && cfg.economy_enable && up_data.economy_switch) begin
            data_in.flags.out_byte_three = up_data.byte_three | cct_pkg::ECON_BIT;
         end
      end else begin
         data_in.flags.ac_update = hit_one;
         data_in.flags.ac_enable = hit_one & ~up_data.byte_five[0];
         data_in.flags.forward   = ~(hit_one | hit_two | hit_three);
      end

      data_in.fahrenheit = up_data.byte_zero[cct_pkg::FAHR_FLAG_BIT];
      data_in.x_cel      = $signed({temp_c, 1'b0});
      data_in.f_neg      = scaled[11];
      data_in.f_mag      = scaled[11] ? scaled_neg[10:0] : scaled[10:0];
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

@@ sv/cct_scale.sv @@
// ----------------------------------------------------------------------------
// cct_scale
// Second stage: Fahrenheit divide by nine and choice of display scale.
// ----------------------------------------------------------------------------
module cct_scale (
   input  logic            clock,
   input  logic            reset,
   input  logic            up_valid,
   output logic            up_ready,
   input  cct_pkg::s1_type up_data,
   output logic            dn_valid,
   input  logic            dn_ready,
   output cct_pkg::s2_type dn_data
);

   logic            valid_ff;
   cct_pkg::s2_type data_ff;
   cct_pkg::s2_type data_in;

   logic [23:0]       recip_prod;
   logic [7:0]        quot;
   logic signed [9:0] quot_s;
   logic signed [9:0] x_fahr;

   always_comb begin
      // reciprocal multiply, exact for magnitudes up to 1830
      recip_prod = {13'b0, up_data.f_mag} * {11'b0, cct_pkg::RECIP_NINE};
      quot       = recip_prod[23:16];
      quot_s     = $signed({2'b0, quot});
      x_fahr     = up_data.f_neg ? -quot_s : quot_s;

      data_in.flags = up_data.flags;
      data_in.x     = up_data.fahrenheit ? x_fahr : up_data.x_cel;
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

@@ sv/cct_dac.sv @@
// ----------------------------------------------------------------------------
// cct_dac
// Third stage: segment slope, line evaluation and result register.
// ----------------------------------------------------------------------------
module cct_dac (
   input  logic            clock,
   input  logic            reset,
   input  logic            up_valid,
   output logic            up_ready,
   input  cct_pkg::s2_type up_data,
   output logic            dn_valid,
   input  logic            dn_ready,
   output cct_pkg::rsp_type dn_data
);

   logic             valid_ff;
   cct_pkg::rsp_type data_ff;
   cct_pkg::rsp_type data_in;

   logic [11:0] slope;
   logic [11:0] x_ext;
   logic [23:0] line_prod;
   logic [11:0] line_val;

   always_comb begin
      if (up_data.x > cct_pkg::SEG_HIGH) begin
         slope = cct_pkg::SLOPE_HIGH;
      end else if (up_data.x < cct_pkg::SEG_MID && up_data.x >= cct_pkg::SEG_LOW) begin
         slope = cct_pkg::SLOPE_MID;
      end else if (up_data.x < cct_pkg::SEG_LOW) begin
         slope = cct_pkg::SLOPE_LOW;
      end else begin
         slope = cct_pkg::SLOPE_UPPER;
      end

      // only the low 12 bits survive, so modular arithmetic is enough
      x_ext     = {{2{up_data.x[9]}}, up_data.x};
      line_prod = {12'b0, x_ext} * {12'b0, slope};
      line_val  = line_prod[11:0] + cct_pkg::LINE_OFFSET;

      data_in.forward        = up_data.flags.forward;
      data_in.out_byte_three = up_data.flags.out_byte_three;
      data_in.dac_write      = up_data.flags.dac_write;
      data_in.dac_value      = up_data.flags.dac_write ? line_val : 12'd0;
      data_in.ac_update      = up_data.flags.ac_update;
      data_in.ac_enable      = up_data.flags.ac_enable;
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

@@ sv/can_climate_frame_translator_unit.sv @@
// ----------------------------------------------------------------------------
// can_climate_frame_translator_unit
// Per-frame forwarding, DAC and AC decisions between car and climate buses.
// ----------------------------------------------------------------------------
// Accepts one frame word per clock while nothing stalls and returns one
// result word per frame, in order, through a three-stage pipeline (id match,
// divide by nine, slope line); the word passes the decode, scale and dac
// registers in turn before it is offered on rsp. Each stage holds its word
// while the next one is full, so back pressure on rsp_tready reaches
// req_tready without loss. Identifier registers must be written through the
// csr port only while no frame is in flight; the block does not enforce it.
module can_climate_frame_translator_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [cct_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [cct_pkg::ID_W-1:0]        csr_wdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // frame_id, byte_zero, byte_two, byte_three, byte_five, economy_switch
   input  logic [cct_pkg::REQ_DATA_W-1:0]  req_tdata,
   // from_unit
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // forward, out_byte_three, dac_write, dac_value, ac_update, ac_enable
   output logic [cct_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   cct_pkg::cfg_type  cfg_ff;
   cct_pkg::req_type  req;
   cct_pkg::s1_type   s1_data;
   cct_pkg::s2_type   s2_data;
   cct_pkg::rsp_type  rsp_data;
   logic              s1_valid;
   logic              s1_ready;
   logic              s2_valid;
   logic              s2_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            cct_pkg::CSR_DISPLAY_FRAME_ID: cfg_ff.display_frame_id <= csr_wdata;
            cct_pkg::CSR_ECONOMY_ID:       cfg_ff.economy_id       <= csr_wdata;
            cct_pkg::CSR_CLIMATE_ID_ONE:   cfg_ff.climate_id_one   <= csr_wdata;
            cct_pkg::CSR_CLIMATE_ID_TWO:   cfg_ff.climate_id_two   <= csr_wdata;
            cct_pkg::CSR_CLIMATE_ID_THREE: cfg_ff.climate_id_three <= csr_wdata;
            cct_pkg::CSR_ECONOMY_ENABLE:   cfg_ff.economy_enable   <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      req.from_unit      = req_tuser;
      req.frame_id       = req_tdata[28:0];
      req.byte_zero      = req_tdata[36:29];
      req.byte_two       = req_tdata[44:37];
      req.byte_three     = req_tdata[52:45];
      req.byte_five      = req_tdata[60:53];
      req.economy_switch = req_tdata[61];
   end

   cct_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .up_valid (req_tvalid),
      .up_ready (req_tready),
      .up_data  (req),
      .dn_valid (s1_valid),
      .dn_ready (s1_ready),
      .dn_data  (s1_data)
   );

   cct_scale u_scale (
      .clock    (clock),
      .reset    (reset),
      .up_valid (s1_valid),
      .up_ready (s1_ready),
      .up_data  (s1_data),
      .dn_valid (s2_valid),
      .dn_ready (s2_ready),
      .dn_data  (s2_data)
   );

   cct_dac u_dac (
      .clock    (clock),
      .reset    (reset),
      .up_valid (s2_valid),
      .up_ready (s2_ready),
      .up_data  (s2_data),
      .dn_valid (rsp_tvalid),
      .dn_ready (rsp_tready),
      .dn_data  (rsp_data)
   );

   assign rsp_tdata = rsp_data;

endmodule
